FILE: rtl/pba_pkg.sv
// shared types, codes and constants of the periodic bandwidth admission block
// no dependencies: compiled first, used by the interfaces, the top level and the testbench
package pba_pkg;

  // table geometry and register reset
  localparam int unsigned FRAMES_DEFAULT = 1024;
  localparam logic [19:0] BUDGET_RESET   = 20'd900000;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_OPEN  = 1'b1;

  // speed codes
  localparam logic [1:0] SPEED_LOW  = 2'd0;
  localparam logic [1:0] SPEED_FULL = 2'd1;

  // endpoint type codes
  localparam logic [1:0] EP_CTRL = 2'd0;
  localparam logic [1:0] EP_ISOC = 2'd1;
  localparam logic [1:0] EP_BULK = 2'd2;
  localparam logic [1:0] EP_INTR = 2'd3;

  // direction codes
  localparam logic [1:0] DIR_IN  = 2'd0;
  localparam logic [1:0] DIR_OUT = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NOTSUP = 2'd2;
  localparam logic [1:0] ST_NOBW   = 2'd3;

  // bit count: 31 + 10 * floor(28 * mp / 3), the divide by 3 done by reciprocal
  localparam logic [31:0] STUFF_NUM     = 32'd28;
  localparam logic [31:0] DIV3_RECIP    = 32'd43691;
  localparam int unsigned DIV3_SHIFT    = 17;
  localparam logic [31:0] BITS_SCALE    = 32'd10;
  localparam logic [16:0] BITS_OVERHEAD = 17'd31;

  // ns per bit scaled by 1000 (or 10 for low speed out)
  localparam logic [31:0] FS_NS_PER_BIT     = 32'd8354;
  localparam logic [31:0] LS_IN_NS_PER_BIT  = 32'd67667;
  localparam logic [31:0] LS_OUT_NS_PER_BIT = 32'd667;

  // exact reciprocals for quotients below 2^30
  localparam logic [31:0] RECIP_1000    = 32'd1099511628;
  localparam int unsigned DIV1000_SHIFT = 40;
  localparam logic [31:0] RECIP_10      = 32'd1717986919;
  localparam int unsigned DIV10_SHIFT   = 34;

  // fixed protocol overheads in ns
  localparam logic [19:0] HOST_DELAY_NS = 20'd700;
  localparam logic [19:0] LS_SETUP_NS   = 20'd667;
  localparam logic [19:0] FS_ISO_IN_NS  = 20'd7268;
  localparam logic [19:0] FS_ISO_OUT_NS = 20'd6265;
  localparam logic [19:0] FS_NONISO_NS  = 20'd9107;
  localparam logic [19:0] LS_IN_NS      = 20'd64060;
  localparam logic [19:0] LS_OUT_NS     = 20'd64107;

  // transfer size clamp
  localparam logic [31:0] DEFAULT_XFER = 32'd65536;
  localparam logic [31:0] MAX_XFER     = 32'd16777216;

  typedef struct packed {
    logic        operation;
    logic [9:0]  frame_index;
    logic [19:0] frame_load_ns;
    logic [1:0]  speed;
    logic [1:0]  ep_type;
    logic [1:0]  direction;
    logic [10:0] max_packet;
    logic [9:0]  period;
    logic [31:0] max_data_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] bus_time_ns;
    logic [6:0]  first_slot;
    logic [7:0]  poll_interval;
    logic [31:0] effective_data_size;
  } rsp_t;

endpackage

FILE: rtl/pba_if.sv
// valid/ready channel interfaces for request and response transactions
// depends on pba_pkg for the payload structs
interface pba_req_if;
  logic          valid;
  logic          ready;
  pba_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pba_rsp_if;
  logic          valid;
  logic          ready;
  pba_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/pba_frame_ram.sv
// frame load table: single write port, single registered read port
// no package dependencies; depth set by the top level
module pba_frame_ram #(
  parameter int unsigned FRAMES = 1024
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(FRAMES)-1:0] waddr_i,
  input  logic [19:0]               wdata_i,
  input  logic [$clog2(FRAMES)-1:0] raddr_i,
  output logic [19:0]               rdata_o
);

  logic [19:0] mem [FRAMES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/periodic_bandwidth_admission.sv
// periodic bandwidth admission: rule check, bus time and frame table scan
// depends on pba_pkg, pba_if (pba_req_if, pba_rsp_if) and pba_frame_ram
//
// channel   dir  width  transaction
// req_i     in   90     write one frame load entry, or open an endpoint
// rsp_o     out  69     status, bus time, phase slot, interval, data size
// cfg_*     in   20     frame budget in ns, written while idle
//
// a write, or an open that fails the rules, is answered in the cycle after it is accepted
// a control or bulk open makes 5 passes through one shared multiplier, then sums the bus time
// an isochronous or interrupt open then also scans the frame table, paced by the
// single read port of the frame table (one entry read per cycle)
// after reset a clearing pass zeroes every table entry; req_i not ready
// a finished result waits in the output register; a stalled rsp_o holds the
// next result in the done state until the register frees up
module periodic_bandwidth_admission #(
  parameter int unsigned FRAMES = pba_pkg::FRAMES_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pba_req_if.sink          req_i,
  pba_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [19:0]      cfg_wdata_i
);

  localparam int unsigned AW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned BW = CW + 1;
  localparam int unsigned OW = AW + 20;
  localparam logic [10:0] FRAMES_L = 11'(FRAMES);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MSCALE = 4'd2;
  localparam logic [3:0] S_MDIV3  = 4'd3;
  localparam logic [3:0] S_MX10   = 4'd4;
  localparam logic [3:0] S_MCOEF  = 4'd5;
  localparam logic [3:0] S_MRECIP = 4'd6;
  localparam logic [3:0] S_BUS    = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_q, state_d;

  // usb rule check of an open request
  function automatic logic [1:0] check_rules(input pba_pkg::req_t r);
    logic [1:0] st;
    st = pba_pkg::ST_BAD;
    if (r.direction != pba_pkg::DIR_IN && r.direction != pba_pkg::DIR_OUT) begin
      st = pba_pkg::ST_BAD;
    end else if (r.ep_type == pba_pkg::EP_ISOC &&
                 r.max_data_size > {21'd0, r.max_packet}) begin
      st = pba_pkg::ST_BAD;
    end else if (r.speed == pba_pkg::SPEED_LOW) begin
      if (r.ep_type == pba_pkg::EP_CTRL) begin
        st = (r.max_packet == 11'd8) ? pba_pkg::ST_OK : pba_pkg::ST_BAD;
      end else if (r.ep_type == pba_pkg::EP_INTR) begin
        st = (r.max_packet <= 11'd8 && (r.period inside {[10'd10:10'd255]}))
             ? pba_pkg::ST_OK : pba_pkg::ST_BAD;
      end else begin
        st = pba_pkg::ST_BAD;
      end
    end else if (r.speed == pba_pkg::SPEED_FULL) begin
      if (r.ep_type == pba_pkg::EP_CTRL || r.ep_type == pba_pkg::EP_BULK) begin
        st = (r.max_packet inside {11'd8, 11'd16, 11'd32, 11'd64})
             ? pba_pkg::ST_OK : pba_pkg::ST_BAD;
      end else if (r.ep_type == pba_pkg::EP_INTR) begin
        st = (r.max_packet <= 11'd64 && (r.period inside {[10'd1:10'd255]}))
             ? pba_pkg::ST_OK : pba_pkg::ST_BAD;
      end else begin
        st = (r.max_packet <= 11'd1023) ? pba_pkg::ST_OK : pba_pkg::ST_BAD;
      end
    end else begin
      st = pba_pkg::ST_NOTSUP;
    end
    return st;
  endfunction

  // power-of-two floor of a period already known to be below 256
  function automatic logic [7:0] floor_pow2(input logic [7:0] p);
    logic [7:0] r;
    r = 8'd0;
    for (int b = 0; b < 8; b++) begin
      if (p[b]) begin
        r = 8'd1 << b;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // handshake and request capture

  logic rsp_vld_q;
  logic rsp_free;
  logic req_fire;
  logic rsp_load;
  logic [1:0] rule_st;

  pba_pkg::rsp_t rsp_q, rsp_d;

  assign rsp_free  = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && rsp_free;
  assign req_fire  = req_i.valid && req_i.ready;
  assign rule_st   = check_rules(req_i.payload);

  // request fields kept while an open is in flight
  logic [1:0]  speed_q, type_q, dir_q;
  logic [10:0] mp_q;
  logic [7:0]  ivl_q;
  logic [31:0] eff_q, eff_d;
  logic [19:0] budget_q;

  always_comb begin
    if (req_i.payload.max_data_size < {21'd0, req_i.payload.max_packet}) begin
      eff_d = pba_pkg::DEFAULT_XFER;
    end else if (req_i.payload.max_data_size > pba_pkg::MAX_XFER) begin
      eff_d = pba_pkg::MAX_XFER;
    end else begin
      eff_d = req_i.payload.max_data_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      speed_q <= req_i.payload.speed;
      type_q  <= req_i.payload.ep_type;
      dir_q   <= req_i.payload.direction;
      mp_q    <= req_i.payload.max_packet;
      eff_q   <= eff_d;
      // isochronous walks every frame as a single slot
      ivl_q   <= (req_i.payload.ep_type == pba_pkg::EP_ISOC)
                 ? 8'd1 : floor_pow2(req_i.payload.period[7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= pba_pkg::BUDGET_RESET;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier: one product per cycle, registered

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;
  logic [16:0] bits10;
  logic        is_iso, is_intr, ls_out, ls_in;
  logic [31:0] coef;
  logic [19:0] base_ns;
  logic [19:0] quot;

  assign is_iso  = (type_q == pba_pkg::EP_ISOC);
  assign is_intr = (type_q == pba_pkg::EP_INTR);
  assign ls_in   = !is_iso && speed_q == pba_pkg::SPEED_LOW && dir_q == pba_pkg::DIR_IN;
  assign ls_out  = !is_iso && speed_q == pba_pkg::SPEED_LOW && dir_q != pba_pkg::DIR_IN;

  // bits on the wire incl. worst case stuffing and overhead
  assign bits10 = prod_q[16:0] + pba_pkg::BITS_OVERHEAD;

  always_comb begin
    if (ls_in) begin
      coef = pba_pkg::LS_IN_NS_PER_BIT;
    end else if (ls_out) begin
      coef = pba_pkg::LS_OUT_NS_PER_BIT;
    end else begin
      coef = pba_pkg::FS_NS_PER_BIT;
    end
  end

  always_comb begin
    if (is_iso) begin
      base_ns = ((dir_q == pba_pkg::DIR_IN) ? pba_pkg::FS_ISO_IN_NS : pba_pkg::FS_ISO_OUT_NS)
                + pba_pkg::HOST_DELAY_NS;
    end else if (speed_q == pba_pkg::SPEED_FULL) begin
      base_ns = pba_pkg::FS_NONISO_NS + pba_pkg::HOST_DELAY_NS;
    end else if (ls_in) begin
      base_ns = pba_pkg::LS_IN_NS + pba_pkg::LS_SETUP_NS + pba_pkg::HOST_DELAY_NS;
    end else begin
      base_ns = pba_pkg::LS_OUT_NS + pba_pkg::LS_SETUP_NS + pba_pkg::HOST_DELAY_NS;
    end
  end

  assign quot = ls_out ? prod_q[pba_pkg::DIV10_SHIFT +: 20]
                       : prod_q[pba_pkg::DIV1000_SHIFT +: 20];

  always_comb begin
    case (state_q)
      S_MSCALE: begin
        mul_a = 32'(mp_q);
        mul_b = pba_pkg::STUFF_NUM;
      end
      S_MDIV3: begin
        mul_a = prod_q[31:0];
        mul_b = pba_pkg::DIV3_RECIP;
      end
      S_MX10: begin
        mul_a = 32'(prod_q[pba_pkg::DIV3_SHIFT +: 14]);
        mul_b = pba_pkg::BITS_SCALE;
      end
      S_MCOEF: begin
        mul_a = 32'(bits10);
        mul_b = coef;
      end
      S_MRECIP: begin
        mul_a = prod_q[31:0];
        mul_b = ls_out ? pba_pkg::RECIP_10 : pba_pkg::RECIP_1000;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic [19:0] bus_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_BUS) begin
      bus_q <= base_ns + quot;
    end
  end

  // ---------------------------------------------------------------------------
  // frame table and scan

  logic [AW-1:0] clr_cnt_q;
  logic [CW-1:0] base_q;
  logic [6:0]    slot_q;
  logic [6:0]    ivl_m1;
  logic [BW-1:0] next_end;
  logic          more;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [19:0]   ram_wdata, ram_rdata;

  assign ivl_m1    = 7'(ivl_q - 8'd1);
  assign next_end  = BW'(base_q) + BW'({ivl_q, 1'b0});
  assign more      = next_end <= BW'(FRAMES);
  assign ram_raddr = AW'(base_q) + AW'(slot_q);

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 20'd0;
    end else begin
      // writes beyond the table are dropped
      ram_we    = req_fire && req_i.payload.operation == pba_pkg::OP_WRITE &&
                  ({1'b0, req_i.payload.frame_index} < FRAMES_L);
      ram_waddr = AW'(req_i.payload.frame_index);
      ram_wdata = req_i.payload.frame_load_ns;
    end
  end

  pba_frame_ram #(
    .FRAMES(FRAMES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // read pipeline tags, registered alongside the frame table read data
  logic          pv_q, plast_q;
  logic [6:0]    pslot_q;
  logic [OW-1:0] occ_q, occ_next, best_q;
  logic          ok_q, ok_next, found_q, fits;
  logic [6:0]    bslot_q;

  assign fits     = ({1'b0, ram_rdata} + {1'b0, bus_q}) <= {1'b0, budget_q};
  assign occ_next = occ_q + OW'(ram_rdata);
  assign ok_next  = ok_q && fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= (state_q == S_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    plast_q <= !more;
    pslot_q <= slot_q;
    if (state_q == S_BUS) begin
      base_q  <= '0;
      slot_q  <= '0;
      occ_q   <= '0;
      ok_q    <= 1'b1;
      found_q <= 1'b0;
    end else begin
      if (state_q == S_SCAN) begin
        if (more) begin
          base_q <= CW'(BW'(base_q) + BW'(ivl_q));
        end else begin
          base_q <= '0;
          slot_q <= slot_q + 7'd1;
        end
      end
      if (pv_q) begin
        if (plast_q) begin
          occ_q <= '0;
          ok_q  <= 1'b1;
          // strict compare keeps the lowest slot on a tie
          if (ok_next && (!found_q || occ_next < best_q)) begin
            found_q <= 1'b1;
            best_q  <= occ_next;
            bslot_q <= pslot_q;
          end
        end else begin
          occ_q <= occ_next;
          ok_q  <= ok_next;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == S_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == AW'(FRAMES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire && req_i.payload.operation == pba_pkg::OP_OPEN &&
            rule_st == pba_pkg::ST_OK) begin
          state_d = S_MSCALE;
        end
      end
      S_MSCALE: state_d = S_MDIV3;
      S_MDIV3:  state_d = S_MX10;
      S_MX10:   state_d = S_MCOEF;
      S_MCOEF:  state_d = S_MRECIP;
      S_MRECIP: state_d = S_BUS;
      S_BUS: begin
        state_d = (is_iso || is_intr) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (!more && slot_q == ivl_m1) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (rsp_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // response register

  always_comb begin
    rsp_d    = '0;
    rsp_load = 1'b0;
    if (req_fire) begin
      // writes answer ok, rule failures answer their code, all else zero
      if (req_i.payload.operation == pba_pkg::OP_WRITE) begin
        rsp_load = 1'b1;
      end else if (rule_st != pba_pkg::ST_OK) begin
        rsp_load     = 1'b1;
        rsp_d.status = rule_st;
      end
    end else if (state_q == S_DONE && rsp_free) begin
      rsp_load = 1'b1;
      if ((is_iso || is_intr) && !found_q) begin
        rsp_d.status = pba_pkg::ST_NOBW;
      end else begin
        rsp_d.status              = pba_pkg::ST_OK;
        rsp_d.bus_time_ns         = bus_q;
        rsp_d.first_slot          = is_intr ? bslot_q : 7'd0;
        rsp_d.poll_interval       = is_intr ? ivl_q : 8'd0;
        rsp_d.effective_data_size = eff_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  // ---------------------------------------------------------------------------
  // checks

  // a refused open carries nothing but its status
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.status != pba_pkg::ST_OK |->
      rsp_o.payload.bus_time_ns == 20'd0 && rsp_o.payload.first_slot == 7'd0 &&
      rsp_o.payload.poll_interval == 8'd0 && rsp_o.payload.effective_data_size == 32'd0)
    else $error("refused open with nonzero fields");

  // a table write is answered in the next cycle
  a_write_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.payload.operation == pba_pkg::OP_WRITE |=>
      rsp_o.valid && rsp_o.payload.status == pba_pkg::ST_OK)
    else $error("write transaction not answered");

  // the scan stays inside the table
  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CW'(ram_raddr) < CW'(FRAMES))
    else $error("scan address beyond frame table");

  // the reported interval is a power of two or zero
  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $onehot0(rsp_o.payload.poll_interval))
    else $error("poll interval not a power of two");

endmodule

FILE: tb/periodic_bandwidth_admission_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of periodic_bandwidth_admission: frame table writes and endpoint opens
// depends on pba_pkg, pba_if and the rtl top level; predicts every response in step with stimulus
module periodic_bandwidth_admission_tb;
  import pba_pkg::*;

  typedef longint unsigned u64_t;

  // table size of the instance (left at its default)
  localparam int unsigned FRAME_COUNT = FRAMES_DEFAULT;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 16000;

  // codes the package leaves unnamed
  localparam logic [1:0] SPEED_RSVD2 = 2'd2;
  localparam logic [1:0] SPEED_RSVD3 = 2'd3;
  localparam logic [1:0] DIR_BAD2    = 2'd2;
  localparam logic [1:0] DIR_BAD3    = 2'd3;

  // bus time terms in ns, taken from the usb bus time formulas
  localparam u64_t NS_HOST      = 700;
  localparam u64_t NS_ISO_IN    = 7268;
  localparam u64_t NS_ISO_OUT   = 6265;
  localparam u64_t NS_FS_XFER   = 9107;
  localparam u64_t NS_LS_IN     = 64060;
  localparam u64_t NS_LS_OUT    = 64107;
  localparam u64_t NS_LS_SETUP  = 667;
  localparam u64_t FS_BIT_X1000 = 8354;
  localparam u64_t LS_IN_X1000  = 67667;
  localparam u64_t LS_OUT_X10   = 667;

  // transfer size clamp
  localparam logic [31:0] XFER_FALLBACK = 32'd65536;
  localparam logic [31:0] XFER_CEILING  = 32'd16777216;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [19:0] cfg_wdata_i;

  pba_req_if req_ch ();
  pba_rsp_if rsp_ch ();

  periodic_bandwidth_admission u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: frame occupancy table and budget register
  logic [19:0] frame_busy_ns [FRAME_COUNT];
  logic [19:0] budget_ns = BUDGET_RESET;

  // predicted responses, oldest first
  rsp_t decisions_due [$];

  // idling controls of the two channel processes
  bit          req_gaps_en = 1'b1;
  bit          rsp_stalls_en = 1'b1;
  int unsigned rsp_hold_cycles = 0;

  // bookkeeping for the summary
  int unsigned mismatch_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned n_opens = 0;
  int unsigned n_budgets = 0;
  int unsigned n_status [4] = '{0, 0, 0, 0};

  initial begin
    for (int i = 0; i < FRAME_COUNT; i++) frame_busy_ns[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a frame takes the endpoint only if its load plus the transaction stays in budget
  function automatic bit frame_fits(input logic [19:0] load, input u64_t bus);
    return u64_t'(load) + bus <= u64_t'(budget_ns);
  endfunction

  // usb parameter rules, in the order the block applies them
  function automatic logic [1:0] rule_status(input req_t r);
    if (r.direction != DIR_IN && r.direction != DIR_OUT) return ST_BAD;
    // an isochronous transfer may not exceed one packet
    if (r.ep_type == EP_ISOC && r.max_data_size > 32'(r.max_packet)) return ST_BAD;
    if (r.speed == SPEED_LOW) begin
      if (r.ep_type == EP_CTRL) return (r.max_packet == 11'd8) ? ST_OK : ST_BAD;
      if (r.ep_type == EP_INTR) begin
        return (r.max_packet <= 11'd8 && r.period >= 10'd10 && r.period <= 10'd255) ?
               ST_OK : ST_BAD;
      end
      return ST_BAD;
    end
    if (r.speed == SPEED_FULL) begin
      if (r.ep_type == EP_CTRL || r.ep_type == EP_BULK) begin
        return (r.max_packet >= 11'd8 && r.max_packet <= 11'd64 &&
                (r.max_packet & (r.max_packet - 11'd1)) == 11'd0) ? ST_OK : ST_BAD;
      end
      if (r.ep_type == EP_INTR) begin
        return (r.max_packet <= 11'd64 && r.period >= 10'd1 && r.period <= 10'd255) ?
               ST_OK : ST_BAD;
      end
      return (r.max_packet <= 11'd1023) ? ST_OK : ST_BAD;
    end
    return ST_NOTSUP;
  endfunction

  // response of one accepted transaction; a table write updates the shadow table
  function automatic rsp_t decide_request(input req_t r);
    rsp_t        d;
    u64_t        mp, bits, bus, occ, best;
    int unsigned span, slot, f;
    bit          found, ok;
    d = '0;
    span = 0;
    slot = 0;
    if (r.operation == OP_WRITE) begin
      if (r.frame_index < FRAME_COUNT) frame_busy_ns[r.frame_index] = r.frame_load_ns;
      return d;
    end
    d.status = rule_status(r);
    if (d.status != ST_OK) return d;

    // worst-case bit count with stuffing
    mp = r.max_packet;
    bits = 31 + 10 * ((56 * mp) / 6);

    if (r.ep_type == EP_ISOC) begin
      bus = ((r.direction == DIR_IN) ? NS_ISO_IN : NS_ISO_OUT) + (FS_BIT_X1000 * bits) / 1000 +
            NS_HOST;
      // every frame must still have room
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (!frame_fits(frame_busy_ns[i], bus)) begin
          d = '0;
          d.status = ST_NOBW;
          return d;
        end
      end
    end else begin
      if (r.speed == SPEED_FULL) begin
        bus = NS_FS_XFER + (FS_BIT_X1000 * bits) / 1000 + NS_HOST;
      end else if (r.direction == DIR_IN) begin
        bus = NS_LS_IN + NS_LS_SETUP + (LS_IN_X1000 * bits) / 1000 + NS_HOST;
      end else begin
        bus = NS_LS_OUT + NS_LS_SETUP + (LS_OUT_X10 * bits) / 10 + NS_HOST;
      end

      if (r.ep_type == EP_INTR) begin
        // polling interval is the power-of-two floor of the period
        span = 1;
        while ((span << 1) <= r.period) span = span << 1;
        // lightest phase with no overflowing frame; ties go to the lowest phase
        found = 1'b0;
        best = 0;
        for (int i = 0; i < span; i++) begin
          occ = 0;
          ok = 1'b1;
          for (int k = 0; ok && k < FRAME_COUNT / span; k++) begin
            f = (i + span * k) % FRAME_COUNT;
            if (!frame_fits(frame_busy_ns[f], bus)) ok = 1'b0;
            else occ += frame_busy_ns[f];
          end
          if (ok && (!found || occ < best)) begin
            found = 1'b1;
            best = occ;
            slot = i;
          end
        end
        if (!found) begin
          d = '0;
          d.status = ST_NOBW;
          return d;
        end
      end
    end

    d.status = ST_OK;
    d.bus_time_ns = bus[19:0];
    d.first_slot = slot[6:0];
    d.poll_interval = span[7:0];
    if (r.max_data_size < 32'(r.max_packet)) d.effective_data_size = XFER_FALLBACK;
    else if (r.max_data_size > XFER_CEILING) d.effective_data_size = XFER_CEILING;
    else d.effective_data_size = r.max_data_size;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic req_t write_item(input logic [9:0] idx, input logic [19:0] load);
    req_t r;
    r = '0;
    r.operation = OP_WRITE;
    r.frame_index = idx;
    r.frame_load_ns = load;
    return r;
  endfunction

  function automatic req_t open_item(input logic [1:0] spd, input logic [1:0] typ,
                                     input logic [1:0] dir, input logic [10:0] mp,
                                     input logic [9:0] per, input logic [31:0] data);
    req_t r;
    r = '0;
    r.operation = OP_OPEN;
    r.speed = spd;
    r.ep_type = typ;
    r.direction = dir;
    r.max_packet = mp;
    r.period = per;
    r.max_data_size = data;
    return r;
  endfunction

  // spread over below-packet, in range, above the clamp and anything
  function automatic logic [31:0] random_data_size(input logic [10:0] mp);
    int unsigned m;
    m = mp;
    case ($urandom_range(0, 3))
      0: return (m == 0) ? 32'd0 : 32'($urandom_range(0, m - 1));
      1: return 32'($urandom_range(m, XFER_CEILING));
      2: return 32'($urandom_range(XFER_CEILING + 1, 32'hFFFF_FFFF));
      default: return 32'($urandom);
    endcase
  endfunction

  // table writes mostly land in a small pool so loads get rewritten often
  function automatic req_t random_write();
    logic [9:0]  idx;
    logic [19:0] load;
    int unsigned roll;
    idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 31)) : 10'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    if (roll < 60) load = 20'($urandom_range(0, 60000));
    else if (roll < 85) load = 20'($urandom_range(0, 200000));
    else load = 20'($urandom_range(0, 1000000));
    return write_item(idx, load);
  endfunction

  // an open that passes the rules but for an occasional oversized isochronous data size
  function automatic req_t random_open();
    req_t r;
    r = '0;
    r.operation = OP_OPEN;
    r.frame_index = 10'($urandom);
    r.frame_load_ns = 20'($urandom_range(0, 1000000));
    r.direction = 2'($urandom_range(0, 1));
    r.period = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 5))
      0: begin
        r.speed = SPEED_LOW;
        r.ep_type = EP_CTRL;
        r.max_packet = 11'd8;
      end
      1: begin
        r.speed = SPEED_LOW;
        r.ep_type = EP_INTR;
        r.max_packet = 11'($urandom_range(0, 8));
        r.period = 10'($urandom_range(0, 1) ? $urandom_range(10, 32) : $urandom_range(10, 255));
      end
      2: begin
        r.speed = SPEED_FULL;
        r.ep_type = EP_CTRL;
        r.max_packet = 11'(8 << $urandom_range(0, 3));
      end
      3: begin
        r.speed = SPEED_FULL;
        r.ep_type = EP_BULK;
        r.max_packet = 11'(8 << $urandom_range(0, 3));
      end
      4: begin
        r.speed = SPEED_FULL;
        r.ep_type = EP_INTR;
        r.max_packet = 11'($urandom_range(0, 64));
        r.period = 10'($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 255));
      end
      default: begin
        r.speed = SPEED_FULL;
        r.ep_type = EP_ISOC;
        r.max_packet = 11'($urandom_range(0, 1023));
      end
    endcase
    if (r.ep_type == EP_ISOC && $urandom_range(0, 9) != 0) begin
      r.max_data_size = 32'($urandom_range(0, r.max_packet));
    end else begin
      r.max_data_size = random_data_size(r.max_packet);
    end
    return r;
  endfunction

  // broken opens: fully random, or a good one with one field spoiled
  function automatic req_t random_noise();
    req_t r;
    r = random_open();
    case ($urandom_range(0, 4))
      0: begin
        r.speed = 2'($urandom_range(0, 3));
        r.ep_type = 2'($urandom_range(0, 3));
        r.direction = 2'($urandom_range(0, 3));
        r.max_packet = 11'($urandom_range(0, 2047));
        r.period = 10'($urandom_range(0, 1023));
        r.max_data_size = 32'($urandom);
      end
      1: r.max_packet = 11'($urandom_range(0, 2047));
      2: r.period = 10'($urandom_range(0, 1023));
      3: r.direction = 2'($urandom_range(0, 3));
      default: r.speed = 2'($urandom_range(0, 3));
    endcase
    return r;
  endfunction

  function automatic req_t random_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return random_write();
    if (roll < 85) return random_open();
    return random_noise();
  endfunction

  // ---------------------------------------------------------------------------
  // request channel
  // ---------------------------------------------------------------------------

  // offers one transaction and returns at the edge that accepts it; valid stays
  // high so a back-to-back call can reuse it, anything that lets time pass
  // afterwards must lower valid first
  task automatic offer_request(input req_t r);
    int unsigned gap;
    rsp_t        d;
    gap = req_gaps_en ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    d = decide_request(r);
    decisions_due.push_back(d);
    if (r.operation == OP_WRITE) begin
      n_writes++;
    end else begin
      n_opens++;
      n_status[d.status]++;
    end
  endtask

  // sender pauses until every predicted response has come back
  task automatic settle_outstanding();
    req_ch.valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // budget register write, only called with the block idle
  task automatic set_budget(input logic [19:0] ns);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ns;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    budget_ns = ns;
    n_budgets++;
  endtask

  // ---------------------------------------------------------------------------
  // response channel
  // ---------------------------------------------------------------------------

  // ready with random stalls; a hold-off request overrides everything
  initial begin : rsp_sink
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles != 0) begin
        stall_left = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else if (stall_left == 0 && rsp_stalls_en && $urandom_range(0, 99) < 35) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // one line per mismatch, printing stops after a while but counting goes on
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_outcome(input rsp_t got);
    rsp_t want;
    if (decisions_due.size() == 0) begin
      report_mismatch($sformatf("response with status %0d but nothing outstanding", got.status));
      return;
    end
    want = decisions_due.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("response %0d status %0d, predicted %0d",
                                n_checked, got.status, want.status));
    if (got.bus_time_ns !== want.bus_time_ns)
      report_mismatch($sformatf("response %0d bus_time_ns %0d, predicted %0d",
                                n_checked, got.bus_time_ns, want.bus_time_ns));
    if (got.first_slot !== want.first_slot)
      report_mismatch($sformatf("response %0d first_slot %0d, predicted %0d",
                                n_checked, got.first_slot, want.first_slot));
    if (got.poll_interval !== want.poll_interval)
      report_mismatch($sformatf("response %0d poll_interval %0d, predicted %0d",
                                n_checked, got.poll_interval, want.poll_interval));
    if (got.effective_data_size !== want.effective_data_size)
      report_mismatch($sformatf("response %0d effective_data_size %0d, predicted %0d",
                                n_checked, got.effective_data_size, want.effective_data_size));
    n_checked++;
  endtask

  // values read at the edge are the ones the block saw
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_outcome(rsp_ch.payload);
  end

  // gives up when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no transaction for %0d cycles, %0d responses outstanding",
             $time, STALL_LIMIT, decisions_due.size());
    $display("periodic_bandwidth_admission verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // check order, every speed/type rule, packet and period extremes, clamping;
  // runs at the budget left by reset
  task automatic test_rule_checks();
    // invalid direction wins over everything else
    offer_request(open_item(SPEED_RSVD2, EP_ISOC, DIR_BAD2, 11'd8, 10'd0, 32'd100));
    offer_request(open_item(SPEED_FULL, EP_BULK, DIR_BAD3, 11'd64, 10'd0, 32'd64));
    // oversized isochronous data is caught before the speed check
    offer_request(open_item(SPEED_RSVD3, EP_ISOC, DIR_IN, 11'd8, 10'd0, 32'd9));
    // unsupported speeds
    offer_request(open_item(SPEED_RSVD2, EP_CTRL, DIR_IN, 11'd8, 10'd0, 32'd8));
    offer_request(open_item(SPEED_RSVD3, EP_INTR, DIR_OUT, 11'd8, 10'd10, 32'd8));
    // low speed: control needs 8 bytes, interrupt period 10..255, no bulk
    offer_request(open_item(SPEED_LOW, EP_CTRL, DIR_IN, 11'd8, 10'd0, 32'd0));
    offer_request(open_item(SPEED_LOW, EP_CTRL, DIR_OUT, 11'd9, 10'd0, 32'd64));
    offer_request(open_item(SPEED_LOW, EP_INTR, DIR_OUT, 11'd8, 10'd10, 32'd8));
    offer_request(open_item(SPEED_LOW, EP_INTR, DIR_IN, 11'd8, 10'd256, 32'd8));
    offer_request(open_item(SPEED_LOW, EP_BULK, DIR_IN, 11'd8, 10'd0, 32'd8));
    // full speed: power-of-two control/bulk packets, data clamped at the ceiling
    offer_request(open_item(SPEED_FULL, EP_BULK, DIR_OUT, 11'd64, 10'd1023, 32'hFFFF_FFFF));
    offer_request(open_item(SPEED_FULL, EP_CTRL, DIR_IN, 11'd48, 10'd0, 32'd48));
    // longest interval, data right at the ceiling
    offer_request(open_item(SPEED_FULL, EP_INTR, DIR_IN, 11'd64, 10'd255, XFER_CEILING));
    // isochronous packet limit
    offer_request(open_item(SPEED_FULL, EP_ISOC, DIR_OUT, 11'd2047, 10'd0, 32'd0));
    offer_request(open_item(SPEED_FULL, EP_ISOC, DIR_IN, 11'd1023, 10'd0, 32'd1023));
  endtask

  // a full frame blocks isochronous and steers interrupt phase; equal loads pick phase 0
  task automatic test_frame_table();
    offer_request(write_item(10'd1023, 20'd1000000));
    offer_request(open_item(SPEED_FULL, EP_ISOC, DIR_IN, 11'd64, 10'd0, 32'd64));
    offer_request(open_item(SPEED_FULL, EP_INTR, DIR_OUT, 11'd8, 10'd2, 32'd8));
    offer_request(write_item(10'd1023, 20'd0));
    offer_request(write_item(10'd2, 20'd100));
    offer_request(write_item(10'd3, 20'd100));
    offer_request(open_item(SPEED_FULL, EP_INTR, DIR_IN, 11'd16, 10'd3, 32'd4));
  endtask

  // zero budget leaves no frame for any transaction, then the largest budget the tests set
  task automatic test_budget_edges();
    settle_outstanding();
    set_budget(20'd0);
    offer_request(open_item(SPEED_FULL, EP_ISOC, DIR_IN, 11'd0, 10'd0, 32'd0));
    offer_request(open_item(SPEED_LOW, EP_INTR, DIR_IN, 11'd0, 10'd10, 32'd0));
    settle_outstanding();
    set_budget(20'd1000000);
    offer_request(open_item(SPEED_FULL, EP_ISOC, DIR_OUT, 11'd1023, 10'd0, 32'd1023));
  endtask

  task automatic test_random_mix(input int unsigned count, input logic [19:0] budget);
    settle_outstanding();
    set_budget(budget);
    repeat (count) offer_request(random_request());
  endtask

  // both sides at full rate
  task automatic test_no_idle();
    settle_outstanding();
    req_gaps_en = 1'b0;
    rsp_stalls_en = 1'b0;
    test_random_mix(100, 20'd1000000);
    settle_outstanding();
    req_gaps_en = 1'b1;
    rsp_stalls_en = 1'b1;
  endtask

  // long receiver hold-off while writes keep coming, so the block fills and
  // stalls its input; then a full pause of the sender in the middle of traffic
  task automatic test_backpressure();
    settle_outstanding();
    req_gaps_en = 1'b0;
    rsp_hold_cycles = 300;
    repeat (40) offer_request(random_write());
    req_gaps_en = 1'b1;
    repeat (20) offer_request(random_request());
    settle_outstanding();
    repeat (20) offer_request(random_request());
    settle_outstanding();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset budget, then the budget extremes
    test_rule_checks();
    test_frame_table();
    test_budget_edges();

    // random traffic over several budget settings
    test_random_mix(130, 20'($urandom_range(850000, 1000000)));
    test_no_idle();
    test_backpressure();
    test_random_mix(100, 20'($urandom_range(100000, 400000)));
    repeat (3) test_random_mix(50, 20'($urandom_range(0, 1000000)));

    // let any stray response show up before closing
    settle_outstanding();
    repeat (64) @(posedge clk_i);

    $display("covered %0d table writes and %0d endpoint opens under %0d budget settings",
             n_writes, n_opens, n_budgets);
    $display("opens admitted %0d, bad parameter %0d, unsupported %0d, out of bandwidth %0d",
             n_status[ST_OK], n_status[ST_BAD], n_status[ST_NOTSUP], n_status[ST_NOBW]);
    if (mismatch_count == 0) begin
      $display("periodic_bandwidth_admission verification clean");
    end else begin
      $display("periodic_bandwidth_admission verification failed");
    end
    $finish;
  end

endmodule
